>>> rtl/ahtd_pkg.sv
package ahtd_pkg;

  // Item kinds carried in the mode field; the fourth code is ignored.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_BIT   = 2'd2;

  localparam logic [6:0] ESCAPE_CODE = 7'd27;
  localparam logic [3:0] ESCAPE_BITS = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_NODE
  } dec_state_t;

  // One result as it is loaded into the output register.
  typedef struct packed {
    logic [7:0] character;
    logic       character_valid;
    logic       string_end;
  } result_t;

endpackage

>>> rtl/ahtd_in_if.sv
interface ahtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        table_select;
  logic [11:0] table_address;
  logic [7:0]  table_byte;
  logic [7:0]  byte_count;
  logic        code_bit;

  modport source (
    output valid, mode, table_select, table_address, table_byte, byte_count, code_bit,
    input  ready
  );
  modport sink (
    input  valid, mode, table_select, table_address, table_byte, byte_count, code_bit,
    output ready
  );
endinterface

>>> rtl/ahtd_out_if.sv
interface ahtd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       character_valid;
  logic       string_end;

  modport source (
    output valid, character, character_valid, string_end,
    input  ready
  );
  modport sink (
    input  valid, character, character_valid, string_end,
    output ready
  );
endinterface

>>> rtl/atsc_huffman_text_decoder.sv
// Program-guide Huffman text decoder, one code bit per input transfer.
// A load, a start or an escaped literal bit is handled in the idle state; a tree bit
// reads its node byte and then decodes it, with a root pointer read before the node
// read on the first tree bit of each character and the first after an in-range load.
// The single port shared by the two byte banks sets these steps.
// A result is loaded into the output register at the end of its decode cycle.
// Reset: synchronous, active low; clears control state, not the table banks.
module atsc_huffman_text_decoder #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  ahtd_in_if.sink    in_ch,
  ahtd_out_if.source out_ch
);
  import ahtd_pkg::*;

  // Each table is split into an even and an odd byte bank, so a root pointer pair
  // is one row and any node byte is one row of one bank.
  localparam int HALF     = (TABLE_DEPTH + 1) / 2;
  localparam int RAM_DEPTH = 2 * HALF;
  localparam int MIDX_W   = $clog2(RAM_DEPTH);
  localparam logic [16:0] DEPTH_L  = 17'(TABLE_DEPTH);
  localparam logic [MIDX_W-1:0] HALF_IDX = MIDX_W'(HALF);

  // Input holding register: the item under work stays here until popped.
  logic        buf_valid_r, buf_valid_nxt;
  logic [1:0]  buf_mode_r;
  logic        buf_sel_r;
  logic [11:0] buf_addr_r;
  logic [7:0]  buf_byte_r;
  logic [7:0]  buf_count_r;
  logic        buf_bit_r;

  // Decoder state.
  dec_state_t  state_r, state_nxt;
  logic        active_table_r, active_table_nxt;
  logic [7:0]  last_char_r, last_char_nxt;
  logic [7:0]  node_offset_r, node_offset_nxt;
  logic [10:0] bits_left_r, bits_left_nxt;
  logic [3:0]  esc_count_r, esc_count_nxt;
  logic [7:0]  esc_shift_r, esc_shift_nxt;
  logic        string_done_r, string_done_nxt;

  // Cached root pointer of the current previous character.
  logic        root_ok_r, root_ok_nxt;
  logic [15:0] root_r, root_nxt;

  // Node read bookkeeping: out-of-table flag and bank of the byte in flight.
  logic        node_oor_r, node_bank_r;
  logic        node_issue;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;

  logic        in_ready, accept, pop, slot_free;
  logic        emit;
  result_t     emit_res;

  // Table bank port.
  logic              ram_en, ram_we_even, ram_we_odd;
  logic [MIDX_W-1:0] ram_idx;
  logic [7:0]        rd_even, rd_odd;

  // Address arithmetic.
  logic [15:0]       na_root;
  logic [16:0]       na;
  logic              na_oor;
  logic [MIDX_W-1:0] na_idx, root_idx, ld_idx;
  logic              ld_in_range;

  // Decode of the node byte and of an escape bit.
  logic [7:0]  nb;
  logic [10:0] bl_dec;
  logic        budget_out;
  logic        node_need_emit, node_done;
  logic [3:0]  esc_dec;
  logic [7:0]  esc_sh;
  logic        esc_need_emit;
  logic        tree_bit;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ready  = !buf_valid_r || pop;
  assign accept    = in_ch.valid && in_ready;

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.character       = out_res_r.character;
  assign out_ch.character_valid = out_res_r.character_valid;
  assign out_ch.string_end      = out_res_r.string_end;

  // In the root cycle take the pointer straight from the banks.
  assign na_root  = (state_r == ST_ROOT) ? {rd_even, rd_odd} : root_r;
  assign na       = {1'b0, na_root} + 17'(node_offset_r) + 17'(buf_bit_r);
  assign na_oor   = (na >= DEPTH_L);
  assign na_idx   = MIDX_W'(na[16:1]) + (active_table_r ? HALF_IDX : '0);
  assign root_idx = MIDX_W'(last_char_r) + (active_table_r ? HALF_IDX : '0);
  assign ld_idx   = MIDX_W'(buf_addr_r[11:1]) + (buf_sel_r ? HALF_IDX : '0);
  assign ld_in_range = ({5'd0, buf_addr_r} < DEPTH_L);

  // A byte beyond the table reads as a branch to offset zero.
  assign nb         = node_oor_r ? 8'd0 : (node_bank_r ? rd_odd : rd_even);
  assign bl_dec     = bits_left_r - 11'd1;
  assign budget_out = (bl_dec == 11'd0);
  assign node_need_emit = budget_out || (nb[7] && (nb[6:0] != ESCAPE_CODE));
  assign node_done      = !node_need_emit || slot_free;

  assign esc_dec       = esc_count_r - 4'd1;
  assign esc_sh        = {esc_shift_r[6:0], buf_bit_r};
  assign esc_need_emit = (esc_dec == 4'd0) || budget_out;

  assign tree_bit = buf_valid_r && (buf_mode_r == MODE_BIT) && !string_done_r
                    && (esc_count_r == 4'd0);

  ahtd_table_ram #(.DEPTH(RAM_DEPTH), .ADDR_W(MIDX_W)) u_even (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we_even),
    .addr  (ram_idx),
    .wdata (buf_byte_r),
    .rdata (rd_even)
  );

  ahtd_table_ram #(.DEPTH(RAM_DEPTH), .ADDR_W(MIDX_W)) u_odd (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we_odd),
    .addr  (ram_idx),
    .wdata (buf_byte_r),
    .rdata (rd_odd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tree_bit) begin
          state_nxt = root_ok_r ? ST_NODE : ST_ROOT;
        end
      end
      ST_ROOT: begin
        state_nxt = ST_NODE;
      end
      ST_NODE: begin
        if (node_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, bank port and results.
  always_comb begin
    pop              = 1'b0;
    ram_en           = 1'b0;
    ram_we_even      = 1'b0;
    ram_we_odd       = 1'b0;
    ram_idx          = root_idx;
    node_issue       = 1'b0;
    emit             = 1'b0;
    emit_res         = '0;
    active_table_nxt = active_table_r;
    last_char_nxt    = last_char_r;
    node_offset_nxt  = node_offset_r;
    bits_left_nxt    = bits_left_r;
    esc_count_nxt    = esc_count_r;
    esc_shift_nxt    = esc_shift_r;
    string_done_nxt  = string_done_r;
    root_ok_nxt      = root_ok_r;
    root_nxt         = root_r;

    unique case (state_r)
      ST_IDLE: begin
        if (buf_valid_r) begin
          unique case (buf_mode_r)
            MODE_LOAD: begin
              pop = 1'b1;
              if (ld_in_range) begin
                // Any load may touch a root pair: drop the cached pointer.
                ram_en      = 1'b1;
                ram_idx     = ld_idx;
                ram_we_even = !buf_addr_r[0];
                ram_we_odd  = buf_addr_r[0];
                root_ok_nxt = 1'b0;
              end
            end
            MODE_START: begin
              if (buf_count_r != 8'd0 || slot_free) begin
                pop              = 1'b1;
                active_table_nxt = buf_sel_r;
                last_char_nxt    = 8'd0;
                node_offset_nxt  = 8'd0;
                esc_count_nxt    = 4'd0;
                esc_shift_nxt    = 8'd0;
                bits_left_nxt    = {buf_count_r, 3'b000};
                root_ok_nxt      = 1'b0;
                string_done_nxt  = 1'b0;
                if (buf_count_r == 8'd0) begin
                  // Empty string: end at once.
                  emit                = 1'b1;
                  emit_res.string_end = 1'b1;
                  string_done_nxt     = 1'b1;
                end
              end
            end
            MODE_BIT: begin
              if (string_done_r) begin
                pop = 1'b1;
              end else if (esc_count_r != 4'd0) begin
                // Shift in one bit of an escaped literal.
                if (!esc_need_emit || slot_free) begin
                  pop           = 1'b1;
                  bits_left_nxt = bl_dec;
                  esc_shift_nxt = esc_sh;
                  esc_count_nxt = esc_dec;
                  if (esc_dec == 4'd0) begin
                    node_offset_nxt = 8'd0;
                    emit            = 1'b1;
                    if (esc_sh == 8'd0) begin
                      emit_res.string_end = 1'b1;
                    end else begin
                      last_char_nxt            = esc_sh;
                      root_ok_nxt              = 1'b0;
                      emit_res.character       = esc_sh;
                      emit_res.character_valid = 1'b1;
                      emit_res.string_end      = budget_out;
                    end
                  end else if (budget_out) begin
                    emit                = 1'b1;
                    emit_res.string_end = 1'b1;
                  end
                  string_done_nxt = emit_res.string_end;
                end
              end else begin
                // Tree bit: read the node now if the root is known, else the root pair.
                ram_en = 1'b1;
                if (root_ok_r) begin
                  ram_idx    = na_idx;
                  node_issue = 1'b1;
                end
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_ROOT: begin
        root_nxt    = {rd_even, rd_odd};
        root_ok_nxt = 1'b1;
        ram_en      = 1'b1;
        ram_idx     = na_idx;
        node_issue  = 1'b1;
      end
      ST_NODE: begin
        if (node_done) begin
          pop           = 1'b1;
          bits_left_nxt = bl_dec;
          if (!nb[7]) begin
            node_offset_nxt = {nb[6:0], 1'b0};
            if (budget_out) begin
              emit                = 1'b1;
              emit_res.string_end = 1'b1;
            end
          end else if (nb[6:0] == ESCAPE_CODE) begin
            node_offset_nxt = 8'd0;
            esc_count_nxt   = ESCAPE_BITS;
            esc_shift_nxt   = 8'd0;
            if (budget_out) begin
              emit                = 1'b1;
              emit_res.string_end = 1'b1;
            end
          end else begin
            node_offset_nxt = 8'd0;
            emit            = 1'b1;
            if (nb[6:0] == 7'd0) begin
              emit_res.string_end = 1'b1;
            end else begin
              last_char_nxt            = {1'b0, nb[6:0]};
              root_ok_nxt              = 1'b0;
              emit_res.character       = {1'b0, nb[6:0]};
              emit_res.character_valid = 1'b1;
              emit_res.string_end      = budget_out;
            end
          end
          string_done_nxt = emit_res.string_end;
        end
      end
      default: begin
      end
    endcase
  end

  assign buf_valid_nxt = accept ? 1'b1 : (pop ? 1'b0 : buf_valid_r);
  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      buf_valid_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      active_table_r <= 1'b0;
      last_char_r    <= 8'd0;
      node_offset_r  <= 8'd0;
      bits_left_r    <= 11'd0;
      esc_count_r    <= 4'd0;
      esc_shift_r    <= 8'd0;
      string_done_r  <= 1'b1;
      root_ok_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      buf_valid_r    <= buf_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      active_table_r <= active_table_nxt;
      last_char_r    <= last_char_nxt;
      node_offset_r  <= node_offset_nxt;
      bits_left_r    <= bits_left_nxt;
      esc_count_r    <= esc_count_nxt;
      esc_shift_r    <= esc_shift_nxt;
      string_done_r  <= string_done_nxt;
      root_ok_r      <= root_ok_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      buf_mode_r  <= in_ch.mode;
      buf_sel_r   <= in_ch.table_select;
      buf_addr_r  <= in_ch.table_address;
      buf_byte_r  <= in_ch.table_byte;
      buf_count_r <= in_ch.byte_count;
      buf_bit_r   <= in_ch.code_bit;
    end
    if (emit) begin
      out_res_r <= emit_res;
    end
    if (node_issue) begin
      node_oor_r  <= na_oor;
      node_bank_r <= na[0];
    end
    root_r <= root_nxt;
  end

`ifndef SYNTH
  a_node_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NODE) |-> buf_valid_r)
    else $error("node decode without an item in the holding register");

  a_root_then_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |=> (state_r == ST_NODE))
    else $error("root read not followed by node decode");

  a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we_even || ram_we_odd) |-> (state_r == ST_IDLE && !(ram_we_even && ram_we_odd)))
    else $error("table write outside idle or into both banks");

  a_end_closes_string: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.string_end) |=> (string_done_r && out_valid_r))
    else $error("string end result did not close the string");

  a_escape_range: assert property (@(posedge clk) disable iff (!rst_n)
    (esc_count_r <= ESCAPE_BITS))
    else $error("escape bit count out of range");
`endif

endmodule

>>> rtl/ahtd_table_ram.sv
module ahtd_table_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // Single port: write, or read with the data registered; hold the data otherwise.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ahtd_pkg::*;

  localparam int TBL_DEPTH = 4096;
  localparam int RAND_ITEMS = 1600;

  // Fourth mode code: the block must swallow it without a result.
  localparam logic [1:0] MODE_NOP = 2'd3;

  // Leaf bytes with special meaning: terminator and escape.
  localparam logic [7:0] LEAF_TERM = 8'h80;
  localparam logic [7:0] LEAF_ESCAPE = {1'b1, ESCAPE_CODE};

  // Unused high region; stores here are real writes that decoding never reads.
  localparam logic [11:0] SPARE_BASE = 12'hF00;

  // One input transfer as the sender sees it.
  typedef struct packed {
    logic [1:0]  mode;
    logic        table_sel;
    logic [11:0] addr;
    logic [7:0]  tbl_byte;
    logic [7:0]  count;
    logic        code_bit;
  } stim_t;

  // Where the expectation of a directed row comes from.
  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_GIVEN
  } exp_kind_t;

  typedef struct {
    stim_t     s;
    exp_kind_t kind;
    result_t   given;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ahtd_in_if  in_bus ();
  ahtd_out_if out_bus ();

  atsc_huffman_text_decoder #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: its own copy of the tables and the string state.
  // ---------------------------------------------------------------------------
  logic [7:0]  tbl_bytes [2][TBL_DEPTH];
  logic        cur_table = 1'b0;
  logic [7:0]  prior_char = 8'h00;
  logic [7:0]  node_ofs = 8'h00;
  logic [10:0] bit_budget = 11'd0;
  logic [3:0]  literal_bits_left = 4'd0;
  logic [7:0]  literal_acc = 8'h00;
  logic        text_done = 1'b1;

  // Results still owed by the block, oldest first.
  result_t expected_text[$];

  int mismatches = 0;
  int n_transfers = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_chars = 0;
  int n_ends = 0;
  int burst_left = 0;

  // Reads past the end of a table come back as zero, i.e. a branch to offset 0.
  function automatic logic [7:0] tbl_read(int unsigned a);
    if (a >= TBL_DEPTH) return 8'h00;
    return tbl_bytes[cur_table][a[11:0]];
  endfunction

  // A full character is in hand: zero closes the string, anything else is emitted
  // and becomes the context for the next root lookup.
  function automatic bit close_char(logic [7:0] ch, logic budget_out, output result_t r);
    r = '0;
    node_ofs = 8'h00;
    if (ch == 8'h00) begin
      r.string_end = 1'b1;
      text_done = 1'b1;
    end else begin
      prior_char = ch;
      r.character = ch;
      r.character_valid = 1'b1;
      r.string_end = budget_out;
      if (budget_out) text_done = 1'b1;
    end
    return 1'b1;
  endfunction

  // Advance the mirror by one transfer; return 1 when it owes a result.
  function automatic bit huff_decode(input stim_t s, output result_t r);
    logic [15:0] root;
    logic [7:0]  node;
    logic        budget_out;
    int unsigned pair;
    int unsigned node_addr;
    r = '0;
    case (s.mode)
      MODE_LOAD: begin
        if (s.addr < TBL_DEPTH) tbl_bytes[s.table_sel][s.addr] = s.tbl_byte;
        return 1'b0;
      end
      MODE_START: begin
        cur_table = s.table_sel;
        prior_char = 8'h00;
        node_ofs = 8'h00;
        literal_bits_left = 4'd0;
        literal_acc = 8'h00;
        bit_budget = {s.count, 3'b000};
        text_done = 1'b0;
        if (s.count == 8'd0) begin
          r.string_end = 1'b1;
          text_done = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_BIT: ;
      default: return 1'b0;
    endcase
    if (text_done) return 1'b0;

    bit_budget = bit_budget - 11'd1;
    budget_out = (bit_budget == 11'd0);

    if (literal_bits_left != 4'd0) begin
      // Shift in an escaped literal, MSB first.
      literal_acc = {literal_acc[6:0], s.code_bit};
      literal_bits_left = literal_bits_left - 4'd1;
      if (literal_bits_left == 4'd0) return close_char(literal_acc, budget_out, r);
    end else begin
      pair = prior_char * 2;
      root = {tbl_read(pair), tbl_read(pair + 1)};
      node_addr = root + node_ofs + s.code_bit;
      node = tbl_read(node_addr);
      if (!node[7]) begin
        node_ofs = {node[6:0], 1'b0};
      end else if (node[6:0] == ESCAPE_CODE) begin
        node_ofs = 8'h00;
        literal_bits_left = ESCAPE_BITS;
        literal_acc = 8'h00;
      end else begin
        return close_char({1'b0, node[6:0]}, budget_out, r);
      end
    end
    if (budget_out) begin
      r.string_end = 1'b1;
      text_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Table layout: root pointers at 0..511, four small 32-byte trees per table,
  // and in table 0 one wide tree whose far pair (offsets 254/255) is written too.
  // Roots only ever point at a tree base or past the table, and tree branches
  // stay in their 32 bytes or reach the far pair, so no unwritten byte is read.
  // ---------------------------------------------------------------------------
  function automatic logic [11:0] tree_base(int k);
    case (k)
      0: return 12'h2A5;
      1: return 12'h5DA;
      2: return 12'h9B3;
      3: return 12'hC6E;
      default: return 12'hE00;
    endcase
  endfunction

  // Half branches (offset 0..30), the rest leaves with some terminators and escapes.
  function automatic logic [7:0] tree_byte();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 8) return 8'($urandom_range(0, 15));
    if (pick == 8) return LEAF_TERM;
    if (pick < 11) return LEAF_ESCAPE;
    return {1'b1, 7'($urandom_range(0, 127))};
  endfunction

  function automatic logic [15:0] pick_root(logic t);
    int pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) return 16'($urandom_range(16'h1000, 16'hFFFF));
    if (t == 1'b0 && pick < 4) return {4'h0, tree_base(4)};
    return {4'h0, tree_base($urandom_range(0, 3))};
  endfunction

  function automatic stim_t random_fields(logic [1:0] m);
    stim_t s;
    s = $urandom;
    s.mode = m;
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns  result %0d: %s", $time, n_results, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps. Hold each item until the
  // handshake completes, then advance the mirror in acceptance order.
  // ---------------------------------------------------------------------------
  task automatic transfer(input stim_t s, input exp_kind_t kind, input result_t given);
    result_t r;
    bit owed;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= s.mode;
    in_bus.table_select  <= s.table_sel;
    in_bus.table_address <= s.addr;
    in_bus.table_byte    <= s.tbl_byte;
    in_bus.byte_count    <= s.count;
    in_bus.code_bit      <= s.code_bit;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    n_transfers++;
    if (s.mode == MODE_START) n_strings++;
    owed = huff_decode(s, r);
    case (kind)
      EXP_PREDICT: if (owed) expected_text.push_back(r);
      EXP_GIVEN:   expected_text.push_back(given);
      default: ;
    endcase
  endtask

  task automatic load_byte(logic t, logic [11:0] a, logic [7:0] v);
    stim_t s;
    s = random_fields(MODE_LOAD);
    s.table_sel = t;
    s.addr = a;
    s.tbl_byte = v;
    transfer(s, EXP_PREDICT, '0);
  endtask

  // Both bytes back to back, so no bit ever sees a half-updated pointer.
  task automatic write_root(logic t, logic [7:0] c, logic [15:0] v);
    load_byte(t, {3'b000, c, 1'b0}, v[15:8]);
    load_byte(t, {3'b000, c, 1'b1}, v[7:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating 16-bit mask that changes every so often; all
  // ready, a random mix, or sparse (long stalls).
  // ---------------------------------------------------------------------------
  logic [15:0] stall_mask = 16'hFFFF;
  int stall_phase = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 2))
        0: stall_mask = 16'hFFFF;
        1: stall_mask = 16'($urandom) | 16'h0001;
        default: stall_mask = 16'h0101;
      endcase
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % 16;
    out_bus.ready <= stall_mask[stall_phase];
  end

  // Compare each result transfer, field by field, against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      n_results++;
      if (out_bus.character_valid) n_chars++;
      if (out_bus.string_end) n_ends++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected result char=%02h valid=%0b end=%0b",
                                  out_bus.character, out_bus.character_valid,
                                  out_bus.string_end));
      end else begin
        want = expected_text.pop_front();
        if (out_bus.character !== want.character)
          report_mismatch($sformatf("character %02h, want %02h",
                                    out_bus.character, want.character));
        if (out_bus.character_valid !== want.character_valid)
          report_mismatch($sformatf("character_valid %0b, want %0b",
                                    out_bus.character_valid, want.character_valid));
        if (out_bus.string_end !== want.string_end)
          report_mismatch($sformatf("string_end %0b, want %0b",
                                    out_bus.string_end, want.string_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows: walked in order after the tables are in place.
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  task automatic add_row(logic [1:0] m, logic t, logic [11:0] a, logic [7:0] v,
                         logic [7:0] cnt, logic cb, exp_kind_t kind,
                         logic [7:0] ch, logic cv, logic se);
    dir_row_t row;
    row.s.mode = m;
    row.s.table_sel = t;
    row.s.addr = a;
    row.s.tbl_byte = v;
    row.s.count = cnt;
    row.s.code_bit = cb;
    row.kind = kind;
    row.given.character = ch;
    row.given.character_valid = cv;
    row.given.string_end = se;
    dir_rows.push_back(row);
  endtask

  initial begin
    stim_t s;
    int n_counted;
    int cap;
    int sent;
    int waited;
    logic t;

    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_LOAD;
    in_bus.table_select = 1'b0;
    in_bus.table_address = '0;
    in_bus.table_byte = '0;
    in_bus.byte_count = '0;
    in_bus.code_bit = 1'b0;
    out_bus.ready = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the trees first, then point the roots at them.
    for (int tb = 0; tb < 2; tb++) begin
      for (int k = 0; k < 4; k++)
        for (int o = 0; o < 32; o++)
          load_byte(tb[0], tree_base(k) + 12'(o), tree_byte());
    end
    // Wide tree in table 0: leaf 'A' | branch to 2, escape | branch to 254,
    // and at 254/255 the terminator and the highest leaf character.
    load_byte(1'b0, tree_base(4) + 12'd0, {1'b1, 7'h41});
    load_byte(1'b0, tree_base(4) + 12'd1, 8'h01);
    load_byte(1'b0, tree_base(4) + 12'd2, LEAF_ESCAPE);
    load_byte(1'b0, tree_base(4) + 12'd3, 8'h7F);
    for (int o = 4; o < 32; o++) load_byte(1'b0, tree_base(4) + 12'(o), tree_byte());
    load_byte(1'b0, tree_base(4) + 12'd254, LEAF_TERM);
    load_byte(1'b0, tree_base(4) + 12'd255, 8'hFF);
    for (int tb = 0; tb < 2; tb++) begin
      for (int c = 0; c < 256; c++) begin
        if (tb == 0 && (c == 8'h00 || c == 8'h41 || c == 8'hFF))
          write_root(1'b0, c[7:0], {4'h0, tree_base(4)});
        else if (tb == 0 && c == 8'h7F)
          write_root(1'b0, c[7:0], 16'hFFFF);   // past the table: every node reads 0
        else
          write_root(tb[0], c[7:0], pick_root(tb[0]));
      end
    end

    // Idle and out-of-string behavior, empty strings.
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_NOP,   1'b1, 12'hFFF, 8'hFF, 8'd255, 1'b1, EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_START, 1'b1, 12'h000, 8'h00, 8'd0,   1'b0, EXP_GIVEN,  8'h00, 1'b0, 1'b1);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b0, EXP_NONE,   8'h00, 1'b0, 1'b0);
    // Longest budget, one character, a load mid-string, then restart over it.
    add_row(MODE_START, 1'b0, 12'h000, 8'h00, 8'd255, 1'b0, EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b0, EXP_GIVEN,  8'h41, 1'b1, 1'b0);
    add_row(MODE_LOAD,  1'b1, 12'hFFF, 8'hFF, 8'd0,   1'b0, EXP_NONE,   8'h00, 1'b0, 1'b0);
    // One byte of budget: walk to the far pair, leaf 127, then past-the-end
    // reads burn the rest of the budget.
    add_row(MODE_START, 1'b0, 12'h000, 8'h00, 8'd1,   1'b0, EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_PREDICT, 8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_PREDICT, 8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_GIVEN,  8'h7F, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++)
      add_row(MODE_BIT, 1'b0, 12'h000, 8'h00, 8'd0, i[0], EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_GIVEN,  8'h00, 1'b0, 1'b1);
    // Terminator leaf at the far pair, then a stray bit after the end.
    add_row(MODE_START, 1'b0, 12'h000, 8'h00, 8'd2,   1'b0, EXP_NONE,   8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_PREDICT, 8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_PREDICT, 8'h00, 1'b0, 1'b0);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b0, EXP_GIVEN,  8'h00, 1'b0, 1'b1);
    add_row(MODE_BIT,   1'b0, 12'h000, 8'h00, 8'd0,   1'b1, EXP_NONE,   8'h00, 1'b0, 1'b0);

    foreach (dir_rows[i]) transfer(dir_rows[i].s, dir_rows[i].kind, dir_rows[i].given);

    // Random strings: mostly short budgets, run to their end, with table
    // rewrites and stray codes mixed in; some are cut short by a new start.
    // The table fill and the directed rows count toward the item total.
    n_counted = n_transfers;
    while (n_counted < RAND_ITEMS) begin
      s = random_fields(MODE_START);
      s.count = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 6));
      transfer(s, EXP_PREDICT, '0);
      n_counted++;
      cap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 96;
      sent = 0;
      while (!text_done && sent < cap) begin
        if ($urandom_range(0, 11) == 0) begin
          t = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              load_byte(t, tree_base((t == 1'b0) ? $urandom_range(0, 4) : $urandom_range(0, 3))
                           + 12'($urandom_range(0, 31)), tree_byte());
              n_counted++;
            end
            5, 6: begin
              write_root(t, 8'($urandom_range(0, 255)), pick_root(t));
              n_counted += 2;
            end
            7, 8: begin
              load_byte(t, SPARE_BASE + 12'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
              n_counted++;
            end
            default: transfer(random_fields(MODE_NOP), EXP_PREDICT, '0);
          endcase
        end else begin
          transfer(random_fields(MODE_BIT), EXP_PREDICT, '0);
          sent++;
          n_counted++;
        end
      end
      // Trailing bits after the end are swallowed; after a cut-short string they decode.
      repeat ($urandom_range(0, 2)) transfer(random_fields(MODE_BIT), EXP_PREDICT, '0);
    end

    in_bus.valid <= 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    waited = 0;
    while (expected_text.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_text.size()));

    $display("Covered %0d input transfers, %0d strings started", n_transfers, n_strings);
    $display("Checked %0d results: %0d characters, %0d string ends", n_results, n_chars, n_ends);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
